// File: hdl/immo_pkg.sv
package immo_pkg;

	// Configuration register indexes
	localparam logic [1:0] REG_TIMER_RELOAD = 2'd0;
	localparam logic [1:0] REG_PAIRING_A    = 2'd1;
	localparam logic [1:0] REG_PAIRING_B    = 2'd2;
	localparam int         CFG_INDEX_W      = 2;
	localparam int         CFG_DATA_W       = 32;

	// Reset value of the timer reload register
	localparam logic [15:0] TIMER_RELOAD_RST = 16'h01F4;

	// State byte and substate codes
	localparam logic [7:0] STATE_VALIDATED = 8'd1;
	localparam logic [7:0] STATE_FORCED    = 8'd5;
	localparam logic [7:0] SUB_BAD_STATE   = 8'd1;
	localparam logic [7:0] SUB_CLEAR_CODE  = 8'd3;

	// Result codes and CAN identifiers
	localparam logic [7:0] CODE_CLEAR      = 8'd0;
	localparam logic [7:0] CODE_BAD_STATE  = 8'd4;
	localparam logic [7:0] CODE_EXPIRED    = 8'd5;
	localparam logic [7:0] CAN_ID_BAD      = 8'h01;
	localparam logic [7:0] CAN_ID_EXPIRED  = 8'hC8;
	localparam logic [7:0] CAN_ID_NONE     = 8'h00;

	// Controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_POST
	} ctl_state_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;
		logic round;
		logic tick;
		logic post;
	} ctl_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic validated;
		logic mix_done;
	} dp_stat_t;

endpackage

// File: hdl/immo_in_if.sv
interface immo_in_if;
	logic        valid;
	logic        ready;
	logic [7:0]  state_byte;
	logic [7:0]  substate;
	logic [15:0] adc_a;
	logic [15:0] adc_b;
	logic [15:0] adc_c;
	logic [15:0] check_w0;
	logic [15:0] check_w1;
	logic [15:0] check_w2;
	logic [15:0] check_w3;

	modport source (
		output valid, state_byte, substate, adc_a, adc_b, adc_c,
		output check_w0, check_w1, check_w2, check_w3,
		input  ready
	);
	modport sink (
		input  valid, state_byte, substate, adc_a, adc_b, adc_c,
		input  check_w0, check_w1, check_w2, check_w3,
		output ready
	);
endinterface

// File: hdl/immo_out_if.sv
interface immo_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  state_out;
	logic [7:0]  result_code;
	logic [31:0] rolling_code;
	logic [15:0] countdown_value;
	logic        can_send;
	logic [7:0]  can_id;
	logic        lamp_off;
	logic        timer_armed;
	logic        checksum_error;
	logic        good_flag;
	logic        keygen_stuck;

	modport source (
		output valid, state_out, result_code, rolling_code, countdown_value,
		output can_send, can_id, lamp_off, timer_armed, checksum_error,
		output good_flag, keygen_stuck,
		input  ready
	);
	modport sink (
		input  valid, state_out, result_code, rolling_code, countdown_value,
		input  can_send, can_id, lamp_off, timer_armed, checksum_error,
		input  good_flag, keygen_stuck,
		output ready
	);
endinterface

// File: hdl/immo_datapath.sv
module immo_datapath #(
	parameter int MAX_KEYGEN_ROUNDS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  immo_pkg::ctl_cmd_t               cmd,
	output immo_pkg::dp_stat_t               stat,
	input  logic                             cfg_we,
	input  logic [immo_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [immo_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  logic [7:0]                       state_byte,
	input  logic [7:0]                       substate,
	input  logic [15:0]                      adc_a,
	input  logic [15:0]                      adc_b,
	input  logic [15:0]                      adc_c,
	input  logic [15:0]                      check_w0,
	input  logic [15:0]                      check_w1,
	input  logic [15:0]                      check_w2,
	input  logic [15:0]                      check_w3,
	output logic [7:0]                       state_out,
	output logic [7:0]                       result_code,
	output logic [31:0]                      rolling_code,
	output logic [15:0]                      countdown_value,
	output logic                             can_send,
	output logic [7:0]                       can_id,
	output logic                             lamp_off,
	output logic                             timer_armed,
	output logic                             checksum_error,
	output logic                             good_flag,
	output logic                             keygen_stuck
);
	import immo_pkg::*;

	localparam int RW = $clog2(MAX_KEYGEN_ROUNDS + 1);

	// Configuration registers
	logic [15:0] timer_reload_q;
	logic [31:0] pairing_a_q;
	logic [31:0] pairing_b_q;

	// Latched word fields
	logic        validated_q;
	logic [7:0]  sub_q;
	logic [15:0] a_q;
	logic [15:0] b_q;
	logic [15:0] c_q;
	logic [31:0] v_q;

	// Architectural state
	logic [15:0] mix_hi_q;
	logic [15:0] mix_lo_q;
	logic [7:0]  mix_count_q;
	logic [31:0] code_q;
	logic [31:0] snap_q;
	logic [15:0] countdown_q;
	logic [7:0]  code_byte_q;
	logic        error_q;
	logic        good_q;
	logic        expired_q;
	logic [RW-1:0] rounds_q;

	// Checked value and mixer round
	logic [15:0] comp;
	logic        chk_ok;
	logic [7:0]  cnt_n;
	logic [15:0] lo_inc;
	logic [15:0] lo_sum;
	logic [15:0] lo_n;
	logic [15:0] hi_n;
	logic [31:0] mixed;
	logic [31:0] code_n;
	logic [RW-1:0] rounds_n;
	logic [15:0] cd_dec;

	// Post-step values
	logic        sub_bad;
	logic [7:0]  code_byte_n;

	assign comp   = ~(check_w0 + check_w1);
	assign chk_ok = (comp == check_w2) || (comp == check_w3);

	// One round of the add-xor mixer on the latched inputs.
	assign cnt_n  = 8'(v_q[7:0] + a_q[7:0] + mix_count_q
		+ {7'd0, (mix_lo_q == 16'hFFFF)} + 8'd1) ^ b_q[7:0];
	assign lo_inc = mix_lo_q + 16'd1;
	assign lo_sum = v_q[23:8] + lo_inc + c_q;
	assign lo_n   = ~({a_q[7:0], b_q[7:0]} ^ lo_sum);
	assign hi_n   = (v_q[31:16] + mix_hi_q + b_q) ^ {c_q[7:0], a_q[7:0]};
	assign mixed  = {hi_n, lo_n};
	assign code_n = (mixed != 32'd0) ? mixed : (pairing_a_q | pairing_b_q);

	assign rounds_n = rounds_q + RW'(1);
	assign cd_dec   = (countdown_q != 16'd0) ? (countdown_q - 16'd1) : 16'd0;

	assign stat.validated = validated_q;
	assign stat.mix_done  = (code_n != snap_q) || (rounds_n == RW'(MAX_KEYGEN_ROUNDS));

	// Substate action on the validated path.
	assign sub_bad = validated_q && (sub_q == SUB_BAD_STATE);
	always_comb begin
		code_byte_n = code_byte_q;
		if (validated_q) begin
			if (sub_q == SUB_BAD_STATE) begin
				code_byte_n = CODE_BAD_STATE;
			end else if (sub_q == SUB_CLEAR_CODE) begin
				code_byte_n = CODE_CLEAR;
			end
		end
	end

	// Configuration writes; indexes past the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timer_reload_q <= TIMER_RELOAD_RST;
			pairing_a_q    <= '0;
			pairing_b_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TIMER_RELOAD: timer_reload_q <= cfg_wdata[15:0];
				REG_PAIRING_A:    pairing_a_q    <= cfg_wdata;
				REG_PAIRING_B:    pairing_b_q    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Word latch; the checked value is resolved once per word.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			validated_q <= (state_byte == STATE_VALIDATED);
			sub_q       <= substate;
			a_q         <= adc_a;
			b_q         <= adc_b;
			c_q         <= adc_c;
			v_q         <= chk_ok ? {check_w0, check_w1} : 32'd0;
		end
	end

	// Round counter and code snapshot
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rounds_q <= '0;
			snap_q   <= code_q;
		end else if (cmd.round) begin
			rounds_q <= rounds_n;
		end
	end

	// Mixer, countdown and sticky state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mix_hi_q    <= '0;
			mix_lo_q    <= '0;
			mix_count_q <= '0;
			code_q      <= '0;
			countdown_q <= '0;
			code_byte_q <= '0;
			error_q     <= 1'b0;
			good_q      <= 1'b0;
			expired_q   <= 1'b0;
		end else begin
			if (cmd.load && (state_byte == STATE_VALIDATED) && !chk_ok) begin
				error_q <= 1'b1;
			end
			if (cmd.round) begin
				mix_hi_q    <= hi_n;
				mix_lo_q    <= lo_n;
				mix_count_q <= cnt_n;
				code_q      <= code_n;
			end
			if (cmd.tick) begin
				if (cd_dec == 16'd0) begin
					expired_q   <= 1'b1;
					countdown_q <= timer_reload_q;
					code_byte_q <= CODE_EXPIRED;
				end else begin
					expired_q   <= 1'b0;
					countdown_q <= cd_dec;
				end
			end
			if (cmd.post) begin
				code_byte_q <= code_byte_n;
				if (sub_bad) begin
					good_q <= 1'b1;
				end
			end
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.post) begin
			state_out       <= validated_q ? STATE_VALIDATED : STATE_FORCED;
			result_code     <= code_byte_n;
			rolling_code    <= code_q;
			countdown_value <= countdown_q;
			checksum_error  <= error_q;
			good_flag       <= good_q | sub_bad;
			timer_armed     <= validated_q;
			keygen_stuck    <= validated_q && (code_q == snap_q);
			if (validated_q) begin
				can_send <= sub_bad;
				lamp_off <= sub_bad;
				can_id   <= sub_bad ? CAN_ID_BAD : CAN_ID_NONE;
			end else begin
				can_send <= expired_q;
				lamp_off <= expired_q;
				can_id   <= expired_q ? CAN_ID_EXPIRED : CAN_ID_NONE;
			end
		end
	end

endmodule

// File: hdl/immo_ctrl.sv
module immo_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               out_ready,
	input  immo_pkg::dp_stat_t stat,
	output logic               in_ready,
	output logic               out_valid,
	output immo_pkg::ctl_cmd_t cmd
);
	import immo_pkg::*;

	ctl_state_t state_q;
	ctl_state_t state_n;
	logic       out_valid_q;
	logic       slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	// Next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_n = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (!stat.validated || stat.mix_done) begin
					state_n = ST_POST;
				end
			end
			ST_POST: begin
				if (slot_free) begin
					state_n = ST_IDLE;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

	// Commands and handshake outputs
	always_comb begin
		in_ready  = 1'b0;
		cmd       = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_EXEC: begin
				cmd.round = stat.validated;
				cmd.tick  = !stat.validated;
			end
			ST_POST: begin
				cmd.post = slot_free;
			end
			default: ;
		endcase
	end

	// State and result valid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.post) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// A result is never written over one that has not been taken.
	a_post_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.post |-> (!out_valid_q || out_ready))
		else $error("result register overwritten");

	// A committed result is offered in the next cycle.
	a_post_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.post |=> out_valid_q)
		else $error("committed result not offered");

	// At most one datapath command per cycle.
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.round, cmd.tick, cmd.post}))
		else $error("conflicting datapath commands");

	// An accepted word always starts execution.
	a_load_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == ST_EXEC))
		else $error("accepted word not executed");

endmodule

// File: hdl/immobilizer_idle_rolling_code.sv
// Channel   Direction  Word contents
// item_in   sink       state byte, substate, three ADC samples, four check words
// item_out  source     state, result code, rolling code, countdown, CAN and flags
// cfg       write      timer reload, pairing word A, pairing word B
//
// A validated word is accepted, runs R mixer rounds (1 to MAX_KEYGEN_ROUNDS, one per
// cycle in the datapath) and then commits its result before the next acceptance.
// Any other word is accepted, takes a countdown step and then commits its result.
// Reset restores the timer reload to 500 and clears the mixer, countdown, sticky flags and controller state.
// A stalled result holds in the output register; the block then waits to commit the next.
module immobilizer_idle_rolling_code #(
	parameter int MAX_KEYGEN_ROUNDS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	immo_in_if.sink                          item_in,
	immo_out_if.source                       item_out,
	input  logic                             cfg_we,
	input  logic [immo_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [immo_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
	import immo_pkg::*;

	ctl_cmd_t cmd;
	dp_stat_t stat;

	// Sequencer
	immo_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item_in.valid),
		.out_ready (item_out.ready),
		.stat      (stat),
		.in_ready  (item_in.ready),
		.out_valid (item_out.valid),
		.cmd       (cmd)
	);

	// Mixer, countdown and result register
	immo_datapath #(
		.MAX_KEYGEN_ROUNDS (MAX_KEYGEN_ROUNDS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata),
		.state_byte      (item_in.state_byte),
		.substate        (item_in.substate),
		.adc_a           (item_in.adc_a),
		.adc_b           (item_in.adc_b),
		.adc_c           (item_in.adc_c),
		.check_w0        (item_in.check_w0),
		.check_w1        (item_in.check_w1),
		.check_w2        (item_in.check_w2),
		.check_w3        (item_in.check_w3),
		.state_out       (item_out.state_out),
		.result_code     (item_out.result_code),
		.rolling_code    (item_out.rolling_code),
		.countdown_value (item_out.countdown_value),
		.can_send        (item_out.can_send),
		.can_id          (item_out.can_id),
		.lamp_off        (item_out.lamp_off),
		.timer_armed     (item_out.timer_armed),
		.checksum_error  (item_out.checksum_error),
		.good_flag       (item_out.good_flag),
		.keygen_stuck    (item_out.keygen_stuck)
	);

endmodule

// File: dv/tb_immobilizer_idle_rolling_code.sv
module tb_immobilizer_idle_rolling_code;

	import immo_pkg::*;

	localparam int          KEYGEN_ROUNDS   = 16;
	localparam int          WORDS_PER_PHASE = 270;
	localparam int          RUN_LIMIT       = 5_000_000;
	// Index 3 is decoded by nobody, so a write to it must change nothing.
	localparam logic [1:0]  REG_UNUSED      = 2'd3;
	// Substate 2 is one of those that the handler leaves alone.
	localparam logic [7:0]  SUB_SKIPPED     = 8'd2;

	typedef struct packed {
		logic [7:0]  state_byte;
		logic [7:0]  substate;
		logic [15:0] adc_a;
		logic [15:0] adc_b;
		logic [15:0] adc_c;
		logic [15:0] check_w0;
		logic [15:0] check_w1;
		logic [15:0] check_w2;
		logic [15:0] check_w3;
	} immo_word_t;

	typedef struct packed {
		logic [7:0]  state_out;
		logic [7:0]  result_code;
		logic [31:0] rolling_code;
		logic [15:0] countdown_value;
		logic        can_send;
		logic [7:0]  can_id;
		logic        lamp_off;
		logic        timer_armed;
		logic        checksum_error;
		logic        good_flag;
		logic        keygen_stuck;
	} immo_status_t;

	typedef enum {CHK_W2, CHK_W3, CHK_BAD, CHK_ANY} check_mode_t;

	// Mirror of the idle handler: registers, mixer state and pending status words.
	class immo_scoreboard;
		logic [15:0]  timer_reload;
		logic [31:0]  pairing_a;
		logic [31:0]  pairing_b;
		logic [15:0]  mix_hi;
		logic [15:0]  mix_lo;
		logic [7:0]   mix_count;
		logic [31:0]  code_reg;
		logic [15:0]  countdown;
		logic [7:0]   code_byte;
		logic         error_sticky;
		logic         good_sticky;
		immo_status_t status_q[$];
		int           mismatches;

		function new();
			timer_reload = TIMER_RELOAD_RST;
			pairing_a    = '0;
			pairing_b    = '0;
			mix_hi       = '0;
			mix_lo       = '0;
			mix_count    = '0;
			code_reg     = '0;
			countdown    = '0;
			code_byte    = '0;
			error_sticky = 1'b0;
			good_sticky  = 1'b0;
			mismatches   = 0;
		endfunction

		function void write_reg(logic [1:0] index, logic [31:0] data);
			case (index)
				REG_TIMER_RELOAD: timer_reload = data[15:0];
				REG_PAIRING_A:    pairing_a = data;
				REG_PAIRING_B:    pairing_b = data;
				default: ;
			endcase
		endfunction

		// A word whose check fails feeds zero into the mixer and latches the error.
		function logic [31:0] checked_value(immo_word_t w);
			logic [15:0] comp;
			comp = ~(w.check_w0 + w.check_w1);
			if (comp == w.check_w2 || comp == w.check_w3)
				return {w.check_w0, w.check_w1};
			error_sticky = 1'b1;
			return '0;
		endfunction

		function void mix_round(immo_word_t w);
			logic [31:0] v;
			logic [31:0] combined;
			v = checked_value(w);
			mix_count = mix_count + v[7:0] + w.adc_a[7:0];
			if (mix_lo == 16'hFFFF)
				mix_count = mix_count + 8'd1;
			mix_lo = mix_lo + 16'd1;
			mix_hi = v[31:16] + mix_hi + w.adc_b;
			mix_count = mix_count + 8'd1;
			mix_lo = v[23:8] + mix_lo + w.adc_c;
			mix_hi = {w.adc_c[7:0], w.adc_a[7:0]} ^ mix_hi;
			mix_lo = ~({w.adc_a[7:0], w.adc_b[7:0]} ^ mix_lo);
			mix_count = w.adc_b[7:0] ^ mix_count;
			combined = {mix_hi, mix_lo};
			// A zero mix falls back to the pairing words.
			code_reg = (combined != '0) ? combined : (pairing_a | pairing_b);
		endfunction

		function void note_input(immo_word_t w);
			immo_status_t s;
			logic [31:0]  snapshot;
			int           rounds;
			s = '0;
			if (w.state_byte == STATE_VALIDATED) begin
				// Rerun the mixer until the code moves or the round cap is hit.
				snapshot = code_reg;
				rounds = 0;
				do begin
					mix_round(w);
					rounds++;
				end while (code_reg == snapshot && rounds < KEYGEN_ROUNDS);
				s.keygen_stuck = (code_reg == snapshot);
				s.timer_armed  = 1'b1;
				s.state_out    = STATE_VALIDATED;
				if (w.substate == SUB_BAD_STATE) begin
					s.lamp_off  = 1'b1;
					s.can_send  = 1'b1;
					s.can_id    = CAN_ID_BAD;
					code_byte   = CODE_BAD_STATE;
					good_sticky = 1'b1;
				end else if (w.substate == SUB_CLEAR_CODE) begin
					code_byte = CODE_CLEAR;
				end
			end else begin
				// Idle path: count down, and on expiry report and reload.
				s.state_out = STATE_FORCED;
				if (countdown != '0)
					countdown = countdown - 16'd1;
				if (countdown == '0) begin
					s.lamp_off = 1'b1;
					s.can_send = 1'b1;
					s.can_id   = CAN_ID_EXPIRED;
					code_byte  = CODE_EXPIRED;
					countdown  = timer_reload;
				end
			end
			s.result_code     = code_byte;
			s.rolling_code    = code_reg;
			s.countdown_value = countdown;
			s.checksum_error  = error_sticky;
			s.good_flag       = good_sticky;
			status_q.push_back(s);
		endfunction

		function int pending();
			return status_q.size();
		endfunction

		task report_mismatch(string msg);
			$display("ERROR at %0t: %s", $time, msg);
			mismatches++;
		endtask

		task compare_field(string name, logic [31:0] got, logic [31:0] want);
			if (got !== want)
				report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
		endtask

		task check_result(immo_status_t got);
			immo_status_t want;
			if (status_q.size() == 0) begin
				report_mismatch("status word with no input word pending");
				return;
			end
			want = status_q.pop_front();
			compare_field("state_out", 32'(got.state_out), 32'(want.state_out));
			compare_field("result_code", 32'(got.result_code), 32'(want.result_code));
			compare_field("rolling_code", got.rolling_code, want.rolling_code);
			compare_field("countdown_value", 32'(got.countdown_value),
				32'(want.countdown_value));
			compare_field("can_send", 32'(got.can_send), 32'(want.can_send));
			compare_field("can_id", 32'(got.can_id), 32'(want.can_id));
			compare_field("lamp_off", 32'(got.lamp_off), 32'(want.lamp_off));
			compare_field("timer_armed", 32'(got.timer_armed), 32'(want.timer_armed));
			compare_field("checksum_error", 32'(got.checksum_error),
				32'(want.checksum_error));
			compare_field("good_flag", 32'(got.good_flag), 32'(want.good_flag));
			compare_field("keygen_stuck", 32'(got.keygen_stuck), 32'(want.keygen_stuck));
		endtask

		task flag_leftovers();
			while (status_q.size() != 0) begin
				void'(status_q.pop_front());
				report_mismatch("expected status word never arrived");
			end
		endtask
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_wdata;
	int                     idle_pct;
	int                     stall_pct;
	immo_scoreboard         sb;

	immo_in_if  in_if ();
	immo_out_if out_if ();

	immobilizer_idle_rolling_code #(
		.MAX_KEYGEN_ROUNDS (KEYGEN_ROUNDS)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_in   (in_if),
		.item_out  (out_if),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// Clock with a 10 unit period.
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Receiver back-pressure, decided once per cycle.
	always @(negedge clk) begin
		out_if.ready <= (stall_pct == 0) || ($urandom_range(0, 99) >= stall_pct);
	end

	// Every accepted status word is checked against the oldest prediction.
	always @(posedge clk) begin
		immo_status_t got;
		if (arst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
			got.state_out       = out_if.state_out;
			got.result_code     = out_if.result_code;
			got.rolling_code    = out_if.rolling_code;
			got.countdown_value = out_if.countdown_value;
			got.can_send        = out_if.can_send;
			got.can_id          = out_if.can_id;
			got.lamp_off        = out_if.lamp_off;
			got.timer_armed     = out_if.timer_armed;
			got.checksum_error  = out_if.checksum_error;
			got.good_flag       = out_if.good_flag;
			got.keygen_stuck    = out_if.keygen_stuck;
			sb.check_result(got);
		end
	end

	function automatic immo_word_t make_word(logic [7:0] st, logic [7:0] sub,
			logic [15:0] a, logic [15:0] b, logic [15:0] c,
			logic [15:0] w0, logic [15:0] w1, logic [15:0] w2, logic [15:0] w3);
		immo_word_t w;
		w.state_byte = st;
		w.substate   = sub;
		w.adc_a      = a;
		w.adc_b      = b;
		w.adc_c      = c;
		w.check_w0   = w0;
		w.check_w1   = w1;
		w.check_w2   = w2;
		w.check_w3   = w3;
		return w;
	endfunction

	// Random samples and check words, with the check made to pass or fail as asked.
	function automatic immo_word_t data_word(logic [7:0] st, logic [7:0] sub, check_mode_t chk);
		immo_word_t  w;
		logic [15:0] comp;
		logic [15:0] flip;
		w = make_word(st, sub, 16'($urandom), 16'($urandom), 16'($urandom),
			16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
		comp = ~(w.check_w0 + w.check_w1);
		case (chk)
			CHK_W2: w.check_w2 = comp;
			CHK_W3: w.check_w3 = comp;
			CHK_BAD: begin
				flip = 16'($urandom_range(1, 65535));
				w.check_w2 = comp ^ flip;
				flip = 16'($urandom_range(1, 65535));
				w.check_w3 = comp ^ flip;
			end
			default: ;
		endcase
		return w;
	endfunction

	// Validated word whose first mixer round lands on zero from the current mixer state.
	// From an all-zero mixer with an unchanged fallback code this sticks for every round.
	function automatic immo_word_t zero_mix_word(logic [7:0] sub);
		logic [7:0]  a8;
		logic [7:0]  b8;
		logic [15:0] a;
		logic [15:0] b;
		logic [15:0] c;
		a8 = 8'($urandom);
		b8 = a8 - sb.mix_hi[7:0];
		c  = ~{a8, b8} - sb.mix_lo - 16'd1;
		b  = {c[7:0], a8} - sb.mix_hi;
		a  = {8'($urandom), a8};
		return make_word(STATE_VALIDATED, sub, a, b, c, 16'h0000, 16'h0000, 16'hFFFF,
			16'($urandom));
	endfunction

	function automatic immo_word_t random_word();
		logic [7:0] st;
		logic [7:0] sub;
		int         r;
		case ($urandom_range(0, 3))
			0: sub = SUB_BAD_STATE;
			1: sub = SUB_CLEAR_CODE;
			2: sub = SUB_SKIPPED;
			default: sub = 8'($urandom_range(0, 255));
		endcase
		if ($urandom_range(0, 99) < 50) begin
			if ($urandom_range(0, 99) < 6)
				return zero_mix_word(sub);
			st = STATE_VALIDATED;
		end else begin
			st = 8'($urandom_range(0, 255));
			if (st == STATE_VALIDATED)
				st = STATE_FORCED;
		end
		r = $urandom_range(0, 99);
		return data_word(st, sub, r < 45 ? CHK_W2 : r < 80 ? CHK_W3 : r < 90 ? CHK_BAD : CHK_ANY);
	endfunction

	// Present one word with an optional random gap ahead of it; return once accepted.
	task automatic send_word(immo_word_t w);
		@(negedge clk);
		while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			in_if.valid <= 1'b0;
			@(negedge clk);
		end
		in_if.valid      <= 1'b1;
		in_if.state_byte <= w.state_byte;
		in_if.substate   <= w.substate;
		in_if.adc_a      <= w.adc_a;
		in_if.adc_b      <= w.adc_b;
		in_if.adc_c      <= w.adc_c;
		in_if.check_w0   <= w.check_w0;
		in_if.check_w1   <= w.check_w1;
		in_if.check_w2   <= w.check_w2;
		in_if.check_w3   <= w.check_w3;
		do
			@(posedge clk);
		while (in_if.ready !== 1'b1);
		sb.note_input(w);
	endtask

	// Drop valid and let the block drain before touching its registers.
	task automatic wait_idle();
		@(negedge clk);
		in_if.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] index, logic [31:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_wdata <= data;
		sb.write_reg(index, data);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_config();
		logic [31:0] data;
		case ($urandom_range(0, 4))
			0: data = 32'd0;
			1: data = 32'd1;
			2: data = $urandom_range(2, 30);
			3: data = 32'h0000_FFFF;
			default: data = $urandom;
		endcase
		write_reg(REG_TIMER_RELOAD, data);
		case ($urandom_range(0, 3))
			0: data = 32'h0000_0000;
			1: data = 32'hFFFF_FFFF;
			default: data = $urandom;
		endcase
		write_reg(REG_PAIRING_A, data);
		write_reg(REG_PAIRING_B, $urandom_range(0, 1) ? 32'h0000_0000 : $urandom);
		if ($urandom_range(0, 1))
			write_reg(REG_UNUSED, $urandom);
	endtask

	initial begin
		#RUN_LIMIT;
		$display("immobilizer_idle_rolling_code: mismatch");
		$finish;
	end

	initial begin
		sb               = new();
		idle_pct         = 0;
		stall_pct        = 0;
		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_index        = '0;
		cfg_wdata        = '0;
		in_if.valid      = 1'b0;
		in_if.state_byte = '0;
		in_if.substate   = '0;
		in_if.adc_a      = '0;
		in_if.adc_b      = '0;
		in_if.adc_c      = '0;
		in_if.check_w0   = '0;
		in_if.check_w1   = '0;
		in_if.check_w2   = '0;
		in_if.check_w3   = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// With both pairing words at zero, a zero mix leaves the code at zero and sticks.
		send_word(zero_mix_word(SUB_SKIPPED));
		wait_idle();
		write_reg(REG_TIMER_RELOAD, 32'd0);
		write_reg(REG_PAIRING_A, 32'h8000_0001);
		write_reg(REG_PAIRING_B, 32'h0123_4560);
		write_reg(REG_UNUSED, 32'hFFFF_FFFF);
		// First zero mix moves the code to the fallback, the second cannot move it.
		send_word(zero_mix_word(SUB_BAD_STATE));
		send_word(zero_mix_word(SUB_CLEAR_CODE));
		// Field extremes with the check word matching in either slot.
		send_word(make_word(STATE_VALIDATED, SUB_BAD_STATE, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			16'hFFFF, 16'hFFFF, 16'h0001, 16'hFFFF));
		send_word(make_word(STATE_VALIDATED, 8'h00, 16'h0000, 16'h0000, 16'h0000,
			16'h0000, 16'h0000, 16'h0000, 16'hFFFF));
		// Idle path with a zero reload expires on every word.
		send_word(data_word(8'h00, 8'h00, CHK_ANY));
		send_word(data_word(8'hFF, 8'hFF, CHK_ANY));
		send_word(data_word(STATE_FORCED, SUB_BAD_STATE, CHK_W2));
		wait_idle();
		write_reg(REG_TIMER_RELOAD, 32'd1);
		repeat (3) send_word(data_word(SUB_SKIPPED, SUB_CLEAR_CODE, CHK_W3));
		wait_idle();
		write_reg(REG_TIMER_RELOAD, 32'h0000_FFFF);
		write_reg(REG_PAIRING_A, 32'hFFFF_FFFF);
		write_reg(REG_PAIRING_B, 32'h0000_0000);
		repeat (2) send_word(data_word(8'h80, SUB_SKIPPED, CHK_ANY));
		send_word(data_word(STATE_VALIDATED, 8'hFF, CHK_W2));
		send_word(data_word(STATE_VALIDATED, SUB_SKIPPED, CHK_W3));
		send_word(zero_mix_word(SUB_BAD_STATE));
		// Failing checks feed zero to the mixer and latch the error flag.
		send_word(make_word(STATE_VALIDATED, SUB_CLEAR_CODE, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000));
		send_word(data_word(STATE_VALIDATED, SUB_BAD_STATE, CHK_BAD));

		// Random phases: free flow, sender gaps, receiver stalls, then both.
		for (int phase = 0; phase < 4; phase++) begin
			wait_idle();
			case (phase)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 78; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 78; end
				default: begin idle_pct = 34; stall_pct = 34; end
			endcase
			random_config();
			repeat (WORDS_PER_PHASE) send_word(random_word());
		end

		@(negedge clk);
		in_if.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		sb.flag_leftovers();
		if (sb.mismatches == 0)
			$display("immobilizer_idle_rolling_code: match");
		else
			$display("immobilizer_idle_rolling_code: mismatch");
		$finish;
	end

endmodule
